@@ hw/rtl/sus_pkg.sv @@
// Package with the shared types, codes and defaults of the sorted unique set unit.
package sus_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_W        = 32;
  localparam int RANK_W       = 6;
  localparam int COUNT_OUT_W  = 7;

  typedef enum logic [1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FIN
  } state_t;

  typedef struct packed {
    logic accept;
    logic srch_rd;
    logic srch_cmp;
    logic shift_rd;
    logic shift_wr;
    logic put;
    logic clear;
    logic read_issue;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic lo_lt_hi;
    logic hit;
    logic full;
    logic sp_gt_lo;
    logic rank_ok;
  } sts_t;

endpackage

@@ hw/rtl/sus_ctrl.sv @@
// Controller state machine that sequences search, shift, insert and result transfer.
module sus_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  sus_pkg::sts_t sts,
  output sus_pkg::cmd_t cmd
);
  import sus_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.op)
          OP_SEARCH, OP_INSERT: begin
            state_nxt = S_SRCH_RD;
          end
          OP_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = S_FIN;
          end
          OP_READ: begin
            cmd.read_issue = sts.rank_ok;
            state_nxt      = S_FIN;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_SRCH_RD: begin
        if (sts.lo_lt_hi) begin
          cmd.srch_rd = 1'b1;
          state_nxt   = S_SRCH_CMP;
        end else if (sts.op == OP_INSERT && !sts.hit && !sts.full) begin
          state_nxt = S_SHIFT_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SRCH_CMP: begin
        cmd.srch_cmp = 1'b1;
        state_nxt    = S_SRCH_RD;
      end
      S_SHIFT_RD: begin
        if (sts.sp_gt_lo) begin
          cmd.shift_rd = 1'b1;
          state_nxt    = S_SHIFT_WR;
        end else begin
          cmd.put   = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = S_SHIFT_RD;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_result = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

@@ hw/rtl/sus_dp.sv @@
// Datapath with the sorted store, binary search bounds, shift pointer and result registers.
module sus_dp #(
  parameter int CAPACITY = sus_pkg::CAPACITY_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [1:0]                             in_opcode,
  input  logic signed [sus_pkg::KEY_W-1:0]       in_key_value,
  input  logic [sus_pkg::RANK_W-1:0]             in_rank_index,
  input  sus_pkg::cmd_t                          cmd,
  output sus_pkg::sts_t                          sts,
  output logic                                   out_found,
  output logic [1:0]                             out_status,
  output logic [sus_pkg::COUNT_OUT_W-1:0]        out_entry_count,
  output logic signed [sus_pkg::KEY_W-1:0]       out_read_value
);
  import sus_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > RANK_W) ? CW : RANK_W;

  logic signed [KEY_W-1:0] store_r [CAPACITY];
  logic signed [KEY_W-1:0] rd_data_r;

  op_t                     op_r;
  logic signed [KEY_W-1:0] key_r;
  logic [RANK_W-1:0]       rank_r;
  logic [CW-1:0]           lo_r, hi_r, sp_r, count_r;
  logic                    hit_r, full_r;

  logic [CW:0]             mid_sum;
  logic [AW-1:0]           mid;
  logic [CW-1:0]           sp_m1;
  logic                    rank_ok;
  logic                    rd_en, wr_en;
  logic [AW-1:0]           rd_addr, wr_addr;
  logic signed [KEY_W-1:0] wr_data;
  status_t                 status_nxt;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[AW:1];
  assign sp_m1   = sp_r - 1'b1;
  assign rank_ok = CMPW'(rank_r) < CMPW'(count_r);

  always_comb begin
    rd_en   = cmd.srch_rd | cmd.shift_rd | cmd.read_issue;
    rd_addr = mid;
    if (cmd.shift_rd) begin
      rd_addr = AW'(sp_m1);
    end else if (cmd.read_issue) begin
      rd_addr = AW'(rank_r);
    end
    wr_en   = cmd.shift_wr | cmd.put;
    wr_addr = cmd.put ? AW'(lo_r) : AW'(sp_r);
    wr_data = cmd.put ? key_r : rd_data_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
    end else if (cmd.put) begin
      count_r <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= op_t'(in_opcode);
      key_r  <= in_key_value;
      rank_r <= in_rank_index;
      lo_r   <= '0;
      hi_r   <= count_r;
      sp_r   <= count_r;
      hit_r  <= 1'b0;
      full_r <= (count_r == CW'(CAPACITY));
    end else if (cmd.srch_cmp) begin
      if (rd_data_r == key_r) begin
        hit_r <= 1'b1;
        hi_r  <= CW'(mid);
      end else if (rd_data_r < key_r) begin
        lo_r <= CW'(mid) + 1'b1;
      end else begin
        hi_r <= CW'(mid);
      end
    end else if (cmd.shift_wr) begin
      sp_r <= sp_m1;
    end
  end

  always_comb begin
    status_nxt = ST_OK;
    case (op_r)
      OP_INSERT: begin
        if (hit_r) begin
          status_nxt = ST_DUP;
        end else if (full_r) begin
          status_nxt = ST_FULL;
        end
      end
      OP_READ: begin
        if (!rank_ok) begin
          status_nxt = ST_RANGE;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_found       <= hit_r && (op_r == OP_SEARCH || op_r == OP_INSERT);
      out_status      <= status_nxt;
      out_entry_count <= COUNT_OUT_W'(count_r);
      out_read_value  <= (op_r == OP_READ && rank_ok) ? rd_data_r : '0;
    end
  end

  assign sts.op       = op_r;
  assign sts.lo_lt_hi = lo_r < hi_r;
  assign sts.hit      = hit_r;
  assign sts.full     = full_r;
  assign sts.sp_gt_lo = sp_r > lo_r;
  assign sts.rank_ok  = rank_ok;

endmodule

@@ hw/rtl/sorted_unique_set_unit.sv @@
// Top level of the sorted unique set unit: controller and datapath.
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+----------------------------------------------
//  in      | in_valid / in_ready   | in_opcode, in_key_value, in_rank_index
//  out     | out_valid / out_ready | out_found, out_status, out_entry_count,
//          |                       | out_read_value
//
// One item is worked on at a time; the next one is taken while the last result waits.
// Clear and read go from decode straight to finish, search does a read and a compare per
// binary search probe (about log2 of the count), and insert of a new key that fits then
// shifts each larger entry by a read and a write, then puts the key, one store read and write per cycle.
// Reset empties the set at once; the store contents stay undefined until written.
// A stalled output holds its result and blocks only the finish of the following item.
module sorted_unique_set_unit #(
  parameter int CAPACITY = sus_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_opcode,
  input  logic signed [sus_pkg::KEY_W-1:0]     in_key_value,
  input  logic [sus_pkg::RANK_W-1:0]           in_rank_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_found,
  output logic [1:0]                           out_status,
  output logic [sus_pkg::COUNT_OUT_W-1:0]      out_entry_count,
  output logic signed [sus_pkg::KEY_W-1:0]     out_read_value
);
  import sus_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sus_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sus_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_opcode       (in_opcode),
    .in_key_value    (in_key_value),
    .in_rank_index   (in_rank_index),
    .cmd             (cmd),
    .sts             (sts),
    .out_found       (out_found),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_read_value  (out_read_value)
  );

endmodule

@@ hw/rtl/sus_checker.sv @@
// Port checker for the sorted unique set unit and its bind to the top level.
module sus_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic [1:0]                           in_opcode,
  input logic signed [sus_pkg::KEY_W-1:0]     in_key_value,
  input logic [sus_pkg::RANK_W-1:0]           in_rank_index,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic                                 out_found,
  input logic [1:0]                           out_status,
  input logic [sus_pkg::COUNT_OUT_W-1:0]      out_entry_count,
  input logic signed [sus_pkg::KEY_W-1:0]     out_read_value
);
  import sus_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_opcode)
      && $stable(in_key_value) && $stable(in_rank_index))
    else $error("Waiting input transfer dropped or changed.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_read_value) && $stable(out_entry_count) && $stable(out_found))
    else $error("Stalled result changed before its transfer.");

  a_dup_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_DUP |-> out_found && out_read_value == '0)
    else $error("Duplicate status without found flag.");

  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL || out_status == ST_RANGE)
      |-> !out_found && out_read_value == '0)
    else $error("Dropped insert or range miss carries found flag or data.");

  a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_OK || out_status == ST_DUP)
    else $error("Found flag set with a failing status.");

endmodule

bind sorted_unique_set_unit sus_checker u_sus_checker (.*);

@@ verif/sorted_unique_set_unit_tb.sv @@
// Self-checking testbench for the sorted unique set unit with random traffic and back-pressure.
module sorted_unique_set_unit_tb;
  import sus_pkg::*;

  localparam int ITEM_TARGET = 1275;
  localparam int IDLE_LIMIT  = 3000;
  localparam int DRAIN_WAIT  = 200;

  typedef struct {
    op_t                      op;
    logic signed [KEY_W-1:0]  key;
    logic [RANK_W-1:0]        rank;
  } set_op_t;

  typedef struct {
    logic                     found;
    status_t                  status;
    logic [COUNT_OUT_W-1:0]   count;
    logic signed [KEY_W-1:0]  value;
  } set_result_t;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [1:0]                    in_opcode = OP_SEARCH;
  logic signed [KEY_W-1:0]       in_key_value = '0;
  logic [RANK_W-1:0]             in_rank_index = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          out_found;
  logic [1:0]                    out_status;
  logic [COUNT_OUT_W-1:0]        out_entry_count;
  logic signed [KEY_W-1:0]       out_read_value;

  set_op_t                  queued_ops[$];
  set_result_t              pending_results[$];
  logic signed [KEY_W-1:0]  set_keys[$];
  logic signed [KEY_W-1:0]  planned_keys[$];

  int mismatch_count = 0;
  int sent_total = 0;
  int got_total = 0;
  int n_search = 0, n_search_hit = 0, n_insert = 0, n_dup = 0, n_full = 0;
  int n_clear = 0, n_read = 0, n_range = 0, max_fill = 0;
  int send_wait = 0;
  int recv_wait = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  set_op_t cur_op;

  sorted_unique_set_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_key_value    (in_key_value),
    .in_rank_index   (in_rank_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_read_value  (out_read_value)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic set_result_t sorted_set_apply(set_op_t it);
    set_result_t r;
    int          pos;
    logic        held;
    r.found  = 1'b0;
    r.status = ST_OK;
    r.value  = '0;
    pos = 0;
    foreach (set_keys[i]) begin
      if (set_keys[i] < it.key) pos++;
    end
    held = 1'b0;
    if (pos < set_keys.size()) held = (set_keys[pos] == it.key);
    case (it.op)
      OP_SEARCH: begin
        n_search++;
        r.found = held;
        if (held) n_search_hit++;
      end
      OP_INSERT: begin
        n_insert++;
        if (held) begin
          r.found  = 1'b1;
          r.status = ST_DUP;
          n_dup++;
        end else if (set_keys.size() >= CAPACITY_DEF) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          set_keys.insert(pos, it.key);
        end
      end
      OP_CLEAR: begin
        n_clear++;
        set_keys.delete();
      end
      default: begin
        n_read++;
        if (it.rank < set_keys.size()) begin
          r.value = set_keys[it.rank];
        end else begin
          r.status = ST_RANGE;
          n_range++;
        end
      end
    endcase
    r.count = COUNT_OUT_W'(set_keys.size());
    if (set_keys.size() > max_fill) max_fill = set_keys.size();
    return r;
  endfunction

  function automatic logic planned_holds(logic signed [KEY_W-1:0] k);
    foreach (planned_keys[i]) begin
      if (planned_keys[i] == k) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed($urandom_range(0, 16)) - 8;
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic logic signed [KEY_W-1:0] fresh_key();
    logic signed [KEY_W-1:0] k;
    k = pick_key();
    while (planned_holds(k)) k = $signed($urandom);
    return k;
  endfunction

  function automatic logic signed [KEY_W-1:0] held_key();
    return planned_keys[$urandom_range(0, planned_keys.size() - 1)];
  endfunction

  function automatic logic [RANK_W-1:0] some_rank();
    if (planned_keys.size() == 0 || $urandom_range(0, 7) == 0)
      return RANK_W'($urandom_range(0, 63));
    return RANK_W'($urandom_range(0, planned_keys.size() - 1));
  endfunction

  task automatic plan_op(op_t op, logic signed [KEY_W-1:0] key, logic [RANK_W-1:0] rank);
    set_op_t it;
    it.op   = op;
    it.key  = key;
    it.rank = rank;
    queued_ops.push_back(it);
    if (op == OP_CLEAR) planned_keys.delete();
    if (op == OP_INSERT && !planned_holds(key) && planned_keys.size() < CAPACITY_DEF)
      planned_keys.push_back(key);
  endtask

  task automatic plan_episode(logic go_full);
    int target;
    int steps;
    int sel;
    plan_op(OP_CLEAR, $signed($urandom), RANK_W'($urandom));
    target = go_full ? CAPACITY_DEF : $urandom_range(1, 24);
    steps  = 2 * target + $urandom_range(0, 10);
    repeat (steps) begin
      sel = $urandom_range(0, 99);
      if (sel < 10)
        plan_op(op_t'($urandom_range(0, 3)), pick_key(), RANK_W'($urandom));
      else if (sel < 50 && planned_keys.size() < target)
        plan_op(OP_INSERT, fresh_key(), RANK_W'($urandom));
      else if (sel < 60 && planned_keys.size() > 0)
        plan_op(OP_INSERT, held_key(), RANK_W'($urandom));
      else if (sel < 72 && planned_keys.size() > 0)
        plan_op(OP_SEARCH, held_key(), RANK_W'($urandom));
      else if (sel < 80)
        plan_op(OP_SEARCH, fresh_key(), RANK_W'($urandom));
      else
        plan_op(OP_READ, pick_key(), some_rank());
    end
    if (go_full) begin
      while (planned_keys.size() < CAPACITY_DEF)
        plan_op(OP_INSERT, fresh_key(), RANK_W'($urandom));
      repeat (3) plan_op(OP_INSERT, fresh_key(), RANK_W'($urandom));
      plan_op(OP_INSERT, held_key(), RANK_W'($urandom));
      plan_op(OP_READ, pick_key(), RANK_W'(CAPACITY_DEF - 1));
      plan_op(OP_READ, pick_key(), '0);
      plan_op(OP_SEARCH, held_key(), RANK_W'($urandom));
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("MISMATCH at result %0d: %s", got_total, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : drive_items
    logic offer;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_wait = $urandom_range(0, 9);
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        pending_results.push_back(sorted_set_apply(cur_op));
        sent_total++;
        offer = 1'b0;
        send_wait = ((sent_total / 150) % 4 == 1) ? 0 : $urandom_range(0, 9);
      end
      if (!offer) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (queued_ops.size() > 0) begin
          cur_op        = queued_ops.pop_front();
          offer         = 1'b1;
          in_opcode     <= cur_op.op;
          in_key_value  <= cur_op.key;
          in_rank_index <= cur_op.rank;
        end
      end
      in_valid <= offer;
    end
  end

  always @(posedge clk) begin : collect_results
    set_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        got_total++;
        if (pending_results.size() == 0) begin
          report_mismatch("result transfer with nothing outstanding");
        end else begin
          want = pending_results.pop_front();
          if (out_found !== want.found)
            report_mismatch($sformatf("found %b, want %b", out_found, want.found));
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
          if (out_entry_count !== want.count)
            report_mismatch($sformatf("entry_count %0d, want %0d", out_entry_count,
                                      want.count));
          if (out_read_value !== want.value)
            report_mismatch($sformatf("read_value %0d, want %0d", out_read_value,
                                      want.value));
        end
        recv_wait = ((got_total / 200) % 4 == 2) ? 0 : $urandom_range(0, 9);
        if (got_total == 300 || got_total == 900) hold_left = 250;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("FAIL sorted_unique_set_unit");
        $finish;
      end
    end
  end

  initial begin
    plan_op(OP_SEARCH, 32'sd5, '0);
    plan_op(OP_READ, '0, '0);
    plan_op(OP_INSERT, 32'sd0, '0);
    plan_op(OP_INSERT, 32'sh7fff_ffff, '0);
    plan_op(OP_INSERT, 32'sh8000_0000, '0);
    plan_op(OP_INSERT, -32'sd1, '0);
    plan_op(OP_INSERT, 32'sd1, '0);
    plan_op(OP_INSERT, 32'sd0, '0);
    plan_op(OP_SEARCH, 32'sh8000_0000, '0);
    plan_op(OP_SEARCH, 32'sh7fff_ffff, '0);
    plan_op(OP_SEARCH, 32'sd2, '0);
    plan_op(OP_READ, '0, 6'd0);
    plan_op(OP_READ, '0, 6'd1);
    plan_op(OP_READ, '0, 6'd4);
    plan_op(OP_READ, '0, 6'd5);
    plan_op(OP_READ, '1, 6'd63);
    plan_op(OP_CLEAR, '0, '0);
    plan_op(OP_SEARCH, 32'sd0, '0);
    plan_op(OP_READ, '0, '0);
    plan_op(OP_INSERT, 32'sh7fff_ffff, '0);
    plan_op(OP_READ, '0, '0);
    plan_episode(1'b1);
    while (queued_ops.size() < ITEM_TARGET)
      plan_episode($urandom_range(0, 9) == 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (queued_ops.size() != 0 || in_valid || pending_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("Covered %0d transfers: %0d searches (%0d hits), %0d inserts",
             got_total, n_search, n_search_hit, n_insert);
    $display("(%0d duplicate, %0d dropped full), %0d clears and %0d reads (%0d out of range).",
             n_dup, n_full, n_clear, n_read, n_range);
    $display("Largest set held %0d values.", max_fill);
    if (mismatch_count == 0) begin
      $display("PASS sorted_unique_set_unit");
    end else begin
      $display("%0d mismatches found", mismatch_count);
      $display("FAIL sorted_unique_set_unit");
    end
    $finish;
  end

endmodule
